// ----- rtl/core/xwg_pkg.sv -----
// Shared types and constants of the xorshift word generator.
package xwg_pkg;

    // State word and its value after reset
    localparam int unsigned WORD_W     = 32;
    localparam logic [31:0] SEED_RESET = 32'hCAFE_BABE;

    // Character codes
    localparam logic [7:0] SPACE_CHAR  = 8'h20;
    localparam logic [7:0] LETTER_BASE = 8'h61;
    localparam logic [7:0] LETTER_LAST = 8'h7A;

    // Word length is MIN_LEN plus the low bits of the state
    localparam int unsigned LEN_BITS = 3;
    localparam int unsigned MIN_LEN  = 3;
    localparam int unsigned LEFT_W   = 4;

    // Register file: byte address width and register index codes
    localparam int unsigned ADDR_W = 3;
    localparam logic        REG_SEED = 1'b0;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SEED,
        S_SPACE,
        S_LETTER
    } t_state;

    // Sequencer strobes to the datapath
    typedef struct packed {
        logic take_item;
        logic adv_state;
        logic emit_space;
        logic emit_letter;
        logic last;
        logic busy;
    } t_ctrl;

endpackage

// ----- rtl/core/xwg_step_unit.sv -----
// Shared xorshift step with the letter that the stepped value selects.
module xwg_step_unit (
    input  logic [xwg_pkg::WORD_W-1:0] i_word,
    output logic [xwg_pkg::WORD_W-1:0] o_next,
    output logic [7:0]                 o_char
);
    import xwg_pkg::*;

    localparam int unsigned SH_A     = 13;
    localparam int unsigned SH_B     = 17;
    localparam int unsigned SH_C     = 5;
    localparam logic [12:0] RECIP_13 = 13'd5042;  // ceil(2^16 / 13)
    localparam logic [12:0] DIV_13   = 13'd13;

    logic [WORD_W-1:0] w_a;
    logic [WORD_W-1:0] w_b;
    logic [WORD_W-1:0] w_c;
    logic [30:0]       w_half;
    logic [13:0]       w_fold1;
    logic [12:0]       w_fold2;
    logic [25:0]       w_prod;
    logic [9:0]        w_quot;
    logic [12:0]       w_back;
    logic [12:0]       w_diff;
    logic [4:0]        w_mod26;

    // Advance the state by one xorshift step
    always_comb begin
        w_a = i_word ^ (i_word << SH_A);
        w_b = w_a ^ (w_a >> SH_B);
        w_c = w_b ^ (w_b << SH_C);
    end

    // Reduce modulo 13 by folding 12-bit chunks (2^12 = 1 mod 13)
    always_comb begin
        w_half  = w_c[31:1];
        w_fold1 = 14'(w_half[11:0]) + 14'(w_half[23:12]) + 14'(w_half[30:24]);
        w_fold2 = 13'(w_fold1[11:0]) + 13'(w_fold1[13:12]);
        w_prod  = 26'(w_fold2) * 26'(RECIP_13);
        w_quot  = w_prod[25:16];
        w_back  = 13'(w_quot) * DIV_13;
        w_diff  = w_fold2 - w_back;
        // x mod 26 = 2 * ((x >> 1) mod 13) + lsb
        w_mod26 = {w_diff[3:0], w_c[0]};
    end

    assign o_next = w_c;
    assign o_char = LETTER_BASE + 8'(w_mod26);

endmodule

// ----- rtl/core/xwg_ctrl.sv -----
// Sequencer: steps one word through seeding, optional space and its letters.
module xwg_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_first_in_line,
    input  logic                          i_out_free,
    input  logic [xwg_pkg::LEN_BITS-1:0]  i_len_bits,
    output xwg_pkg::t_ctrl                o_ctrl
);
    import xwg_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic              r_space;
    logic              n_space;
    logic [LEFT_W-1:0] r_left;
    logic [LEFT_W-1:0] n_left;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_SEED;
            end
            S_SEED: begin
                n_state = r_space ? S_SPACE : S_LETTER;
            end
            S_SPACE: begin
                if (i_out_free) n_state = S_LETTER;
            end
            S_LETTER: begin
                if (i_out_free && (r_left == '0)) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Strobes and counters
    always_comb begin
        o_ctrl  = '0;
        n_space = r_space;
        n_left  = r_left;
        unique case (r_state)
            S_IDLE: begin
                o_ctrl.take_item = i_in_valid;
                if (i_in_valid) n_space = ~i_first_in_line;
            end
            S_SEED: begin
                o_ctrl.busy      = 1'b1;
                o_ctrl.adv_state = 1'b1;
                // Letters left after the first one
                n_left = LEFT_W'(MIN_LEN - 1) + LEFT_W'(i_len_bits);
            end
            S_SPACE: begin
                o_ctrl.busy       = 1'b1;
                o_ctrl.emit_space = i_out_free;
            end
            S_LETTER: begin
                o_ctrl.busy        = 1'b1;
                o_ctrl.emit_letter = i_out_free;
                o_ctrl.last        = (r_left == '0);
                if (i_out_free && (r_left != '0)) n_left = r_left - 1'b1;
            end
            default: begin
                o_ctrl.busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_space <= 1'b0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_space <= n_space;
            r_left  <= n_left;
        end
    end

endmodule

// ----- rtl/core/xwg_top_unit.sv -----
// Start-state select: the seed on a new corpus, else the running generator state.
module xwg_top_unit (
    input  logic [xwg_pkg::WORD_W-1:0] i_seed,
    input  logic [xwg_pkg::WORD_W-1:0] i_gen,
    input  logic                       i_new_corpus,
    output logic [xwg_pkg::WORD_W-1:0] o_start
);
    import xwg_pkg::*;

    // Pick the starting state of a word: seed on a new corpus, else carry on
    assign o_start = i_new_corpus ? i_seed : i_gen;

endmodule

// ----- rtl/core/xorshift_word_generator_unit.sv -----
// Top level of the xorshift word generator: register port, datapath, result stage.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall): each item asks for one word.
//   i_new_corpus reloads the generator state from the seed register first;
//   i_first_in_line suppresses the leading space.
//   Output channel (o_out_valid / i_out_stall): one character per item
//   delivered, a space first unless the word starts a line, then 3 to 10
//   letters; o_last marks the final letter.
//   Sequence: the sequencer takes the item and advances the generator state,
//   then emits one character per cycle while the receiver does not stall; a
//   word has 3 to 11 characters. The single xorshift step unit serves
//   the state advance and every letter. After accept, S_SEED comes first,
//   then the space or letter state loads the first character into the result
//   register. A stalled receiver freezes it and holds the space and letter states;
//   the next item is taken while the last character still waits.
//   Reset returns the sequencer to idle, drops any pending character, and
//   loads 0xCAFEBABE into both the generator state and the seed register.
//   Write the seed register (byte address 0) only while idle.
module xorshift_word_generator_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Register port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [xwg_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    // Request channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_new_corpus,
    input  logic                       i_first_in_line,
    // Character channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [7:0]                 o_character,
    output logic                       o_last
);
    import xwg_pkg::*;

    logic [WORD_W-1:0] r_seed;
    logic [WORD_W-1:0] r_gen;
    logic [WORD_W-1:0] r_work;
    logic              r_out_valid;
    logic [7:0]        r_char;
    logic              r_last;

    logic [WORD_W-1:0] w_start;
    logic [WORD_W-1:0] w_next;
    logic [7:0]        w_letter;
    logic              w_out_free;
    logic              w_reg_wr;
    t_ctrl             w_ctrl;

    // Register port
    assign pready   = 1'b1;
    assign w_reg_wr = psel && penable && pwrite && (paddr[2] == REG_SEED);
    assign prdata   = (paddr[2] == REG_SEED) ? r_seed : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_RESET;
        end else if (w_reg_wr) begin
            r_seed <= pwdata;
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = w_ctrl.busy;

    xwg_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_first_in_line (i_first_in_line),
        .i_out_free      (w_out_free),
        .i_len_bits      (w_next[LEN_BITS-1:0]),
        .o_ctrl          (w_ctrl)
    );

    xwg_top_unit u_start (
        .i_seed       (r_seed),
        .i_gen        (r_gen),
        .i_new_corpus (i_new_corpus),
        .o_start      (w_start)
    );

    xwg_step_unit u_step (
        .i_word (r_work),
        .o_next (w_next),
        .o_char (w_letter)
    );

    // Generator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen <= SEED_RESET;
        end else if (w_ctrl.adv_state) begin
            r_gen <= w_next;
        end
    end

    // Working value: load on take, advance on state step and each letter
    always_ff @(posedge i_clk) begin
        if (w_ctrl.take_item) begin
            r_work <= w_start;
        end else if (w_ctrl.adv_state || w_ctrl.emit_letter) begin
            r_work <= w_next;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.emit_space || w_ctrl.emit_letter) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.emit_space) begin
            r_char <= SPACE_CHAR;
            r_last <= 1'b0;
        end else if (w_ctrl.emit_letter) begin
            r_char <= w_letter;
            r_last <= w_ctrl.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

    // Busy right after an item is taken
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken while sequencer not left idle");

    // A space never ends a word
    a_space_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last) |-> (o_character != SPACE_CHAR))
        else $error("last flag on a space");

    // Every non-space character is a lower-case letter
    a_letter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_character != SPACE_CHAR)) |->
        ((o_character >= LETTER_BASE) && (o_character <= LETTER_LAST)))
        else $error("character outside the alphabet");

    // No new character is loaded while the receiver holds the old one
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !(w_ctrl.emit_space || w_ctrl.emit_letter))
        else $error("result register overwritten while stalled");

endmodule
